FILE: rtl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants of the periodic task tick scheduler: command and
// status codes, the layout of one table entry and the controller states.
// ----------------------------------------------------------------------------
package ptts_pkg;

    // fixed field widths
    localparam int CMD_W      = 3;
    localparam int HANDLE_W   = 8;
    localparam int MS_W       = 32;
    localparam int PEND_W     = 8;
    localparam int DEL_W      = 6;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 4;

    // stream word widths
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 16;

    // at most this many runs are handed out per dispatch
    localparam int RESULT_CAP = 16;
    localparam int NRUN_W     = 5;

    // command codes
    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_TICK     = 3'd0;
    localparam cmd_t CMD_ADD      = 3'd1;
    localparam cmd_t CMD_DISPATCH = 3'd2;
    localparam cmd_t CMD_DELETE   = 3'd3;
    localparam cmd_t CMD_CLEAR    = 3'd4;

    // status codes
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_RANGE = 2'd2;

    localparam logic [PEND_W-1:0] PEND_MAX = 8'hFF;

    // one table entry as held in the entry memory
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [MS_W-1:0]     delay;
        logic [MS_W-1:0]     period;
        logic [PEND_W-1:0]   pending;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

FILE: rtl/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Compacted task table in a one-port-read, one-port-write memory. Tick,
// dispatch and delete walk the table one slot per cycle while not stalled,
// reading the next entry while the current one is written back; add divides
// by the tick length in a reciprocal-multiply divider.
//
//  channel | dir | handshake         | word
//  s_      | in  | s_tvalid/s_tready | tuser command, tdata add/delete fields
//  m_      | out | m_tvalid/m_tready | tuser status, tdata slot/run, tlast
//
// Tick and dispatch walk every valid entry once (no walk when the table is
// empty). Delete walks only the entries behind the removed slot.
// Add runs the three-step divider; on a full table it skips the divider.
// Clear and unknown commands go straight to the final word. A stalled output
// holds the final word of a command, and holds a dispatch walk when a further
// run is found.
// Reset is immediate: no clearing pass.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler import ptts_pkg::*; #(
    parameter int MAX_TASKS = 16,
    parameter int TICK_MS   = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: task_handle[7:0], delay_ms[39:8], period_ms[71:40],
    //          slot_to_delete[77:72], zero fill[79:78]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: command[2:0]
    input  logic [CMD_W-1:0]     s_tuser,
    // m_tdata: slot[3:0], run_valid[4], run_handle[12:5], zero fill[15:13]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: status[1:0]
    output logic [STATUS_W-1:0]  m_tuser,
    output logic                 m_tlast
);

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int XW = DEL_W + 1;
    localparam logic [CW-1:0]     FULL_C = CW'(MAX_TASKS);
    localparam logic [XW-1:0]     SLOTS_X = XW'(MAX_TASKS);
    localparam logic [NRUN_W-1:0] CAP_C  = NRUN_W'(RESULT_CAP);

    // input word fields
    logic [HANDLE_W-1:0] in_handle;
    logic [MS_W-1:0]     in_delay;
    logic [MS_W-1:0]     in_period;
    logic [DEL_W-1:0]    in_del_slot;

    assign in_handle   = s_tdata[7:0];
    assign in_delay    = s_tdata[39:8];
    assign in_period   = s_tdata[71:40];
    assign in_del_slot = s_tdata[77:72];

    state_t state_reg, state_next;

    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         walk_end_reg, walk_end_next;
    logic [CW-1:0]         rd_reg, rd_next;
    logic [CW-1:0]         wr_reg, wr_next;
    logic [NRUN_W-1:0]     nrun_reg, nrun_next;
    cmd_t                  cmd_reg, cmd_next;
    status_t               status_reg, status_next;
    logic [HANDLE_W-1:0]   add_handle_reg, add_handle_next;
    logic                  held_valid_reg, held_valid_next;
    logic [SLOT_OUT_W-1:0] held_slot_reg, held_slot_next;
    logic [HANDLE_W-1:0]   held_handle_reg, held_handle_next;

    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [SLOT_OUT_W-1:0] m_slot_reg, m_slot_next;
    logic                  m_run_reg, m_run_next;
    logic [HANDLE_W-1:0]   m_handle_reg, m_handle_next;
    logic                  m_last_reg, m_last_next;

    logic in_acc;
    logic out_free;

    // memory and divider hookup
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic               div_start;
    logic               div_done;
    logic [MS_W-1:0]    div_qa;
    logic [MS_W-1:0]    div_qb;

    // command decode on accept
    logic          dec_walk;
    logic          dec_div;
    status_t       dec_status;
    logic [SLOT_OUT_W-1:0] dec_slot;
    logic [CW-1:0] dec_start;
    logic [CW-1:0] dec_wr;
    logic [CW-1:0] dec_count;
    logic [XW-1:0] del_x;
    logic [XW-1:0] del_x1;

    // walk evaluation
    entry_t        ent;
    entry_t        ent_mod;
    logic          emit;
    logic          drop;
    logic          need_push;
    logic          advance;
    logic          last_entry;
    logic [CW-1:0] rd_inc;

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    ptts_mem #(
        .DEPTH (MAX_TASKS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    ptts_div #(
        .DIVISOR (TICK_MS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a_in    (in_delay),
        .b_in    (in_period),
        .done    (div_done),
        .qa      (div_qa),
        .qb      (div_qb)
    );

    // decode of the command word, valid entries form a prefix of the table
    always_comb begin
        del_x      = {1'b0, in_del_slot};
        del_x1     = del_x + XW'(1);
        dec_walk   = 1'b0;
        dec_div    = 1'b0;
        dec_status = STATUS_OK;
        dec_slot   = '0;
        dec_start  = '0;
        dec_wr     = '0;
        dec_count  = count_reg;
        unique case (s_tuser)
            CMD_TICK, CMD_DISPATCH: begin
                dec_walk = (count_reg != '0);
            end
            CMD_ADD: begin
                if (count_reg == FULL_C) begin
                    dec_status = STATUS_FULL;
                end else begin
                    dec_div = 1'b1;
                end
            end
            CMD_DELETE: begin
                dec_slot = in_del_slot[SLOT_OUT_W-1:0];
                if (del_x >= SLOTS_X) begin
                    dec_status = STATUS_RANGE;
                end else if (del_x < XW'(count_reg)) begin
                    dec_count = count_reg - 1'b1;
                    dec_walk  = (del_x1 < XW'(count_reg));
                    dec_start = CW'(del_x1);
                    dec_wr    = CW'(del_x);
                end
            end
            CMD_CLEAR: begin
                dec_count = '0;
            end
            default: begin
            end
        endcase
    end

    // evaluation of the entry read in the previous cycle
    always_comb begin
        ent        = entry_t'(mem_rd_data);
        ent_mod    = ent;
        emit       = (cmd_reg == CMD_DISPATCH) && (ent.pending != '0) && (nrun_reg < CAP_C);
        drop       = emit && (ent.period == '0);
        need_push  = emit && held_valid_reg;
        advance    = !(need_push && !out_free);
        rd_inc     = rd_reg + 1'b1;
        last_entry = (rd_inc >= walk_end_reg);
        case (cmd_reg)
            CMD_TICK: begin
                if (ent.delay == '0) begin
                    if (ent.pending != PEND_MAX) begin
                        ent_mod.pending = ent.pending + 1'b1;
                    end
                    if (ent.period != '0) begin
                        ent_mod.delay = ent.period;
                    end
                end else begin
                    ent_mod.delay = ent.delay - 1'b1;
                end
            end
            CMD_DISPATCH: begin
                if (emit) begin
                    ent_mod.pending = ent.pending - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (dec_div) begin
                        state_next = ST_DIV;
                    end else if (dec_walk) begin
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_WALK: begin
                if (advance && last_entry) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath, memory ports and result word per state
    always_comb begin
        count_next       = count_reg;
        walk_end_next    = walk_end_reg;
        rd_next          = rd_reg;
        wr_next          = wr_reg;
        nrun_next        = nrun_reg;
        cmd_next         = cmd_reg;
        status_next      = status_reg;
        add_handle_next  = add_handle_reg;
        held_valid_next  = held_valid_reg;
        held_slot_next   = held_slot_reg;
        held_handle_next = held_handle_reg;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = rd_inc[AW-1:0];
        mem_wr_en        = 1'b0;
        mem_wr_addr      = wr_reg[AW-1:0];
        mem_wr_data      = ent_mod;
        div_start        = 1'b0;
        m_valid_next     = m_valid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_slot_next      = m_slot_reg;
        m_run_next       = m_run_reg;
        m_handle_next    = m_handle_reg;
        m_last_next      = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    cmd_next         = s_tuser;
                    status_next      = dec_status;
                    add_handle_next  = in_handle;
                    held_valid_next  = 1'b0;
                    held_slot_next   = dec_slot;
                    held_handle_next = '0;
                    nrun_next        = '0;
                    count_next       = dec_count;
                    walk_end_next    = count_reg;
                    rd_next          = dec_start;
                    wr_next          = dec_wr;
                    mem_rd_en        = dec_walk;
                    mem_rd_addr      = dec_start[AW-1:0];
                    div_start        = dec_div;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    mem_wr_en      = 1'b1;
                    mem_wr_addr    = count_reg[AW-1:0];
                    mem_wr_data    = entry_t'{handle: add_handle_reg, delay: div_qa,
                                              period: div_qb, pending: '0};
                    count_next     = count_reg + 1'b1;
                    held_slot_next = SLOT_OUT_W'(count_reg);
                end
            end
            ST_WALK: begin
                if (advance) begin
                    // hand out the earlier run when a new one is found
                    if (need_push) begin
                        m_valid_next  = 1'b1;
                        m_status_next = STATUS_OK;
                        m_slot_next   = held_slot_reg;
                        m_run_next    = 1'b1;
                        m_handle_next = held_handle_reg;
                        m_last_next   = 1'b0;
                    end
                    if (emit) begin
                        held_valid_next  = 1'b1;
                        held_slot_next   = SLOT_OUT_W'(wr_reg);
                        held_handle_next = ent.handle;
                        nrun_next        = nrun_reg + 1'b1;
                    end
                    // write back compacted, a finished one-shot is dropped
                    if (drop) begin
                        count_next = count_reg - 1'b1;
                    end else begin
                        mem_wr_en = 1'b1;
                        wr_next   = wr_reg + 1'b1;
                    end
                    if (!last_entry) begin
                        mem_rd_en = 1'b1;
                        rd_next   = rd_inc;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_slot_next   = held_slot_reg;
                    m_run_next    = held_valid_reg;
                    m_handle_next = held_handle_reg;
                    m_last_next   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            held_valid_reg <= held_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        walk_end_reg    <= walk_end_next;
        rd_reg          <= rd_next;
        wr_reg          <= wr_next;
        nrun_reg        <= nrun_next;
        cmd_reg         <= cmd_next;
        status_reg      <= status_next;
        add_handle_reg  <= add_handle_next;
        held_slot_reg   <= held_slot_next;
        held_handle_reg <= held_handle_next;
        m_status_reg    <= m_status_next;
        m_slot_reg      <= m_slot_next;
        m_run_reg       <= m_run_next;
        m_handle_reg    <= m_handle_next;
        m_last_reg      <= m_last_next;
    end

    // result word
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_handle_reg, m_run_reg, m_slot_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/ptts_div.sv
// ----------------------------------------------------------------------------
// ptts_div
// Two-lane divider by a fixed divisor. Turns the delay and period in ms into
// ticks: a reciprocal multiply gives a quotient at most one low, a multiply
// back gives its remainder and one compare and add corrects it.
// ----------------------------------------------------------------------------
module ptts_div import ptts_pkg::*; #(
    parameter int DIVISOR = 10
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [MS_W-1:0] a_in,
    input  logic [MS_W-1:0] b_in,
    output logic            done,
    output logic [MS_W-1:0] qa,
    output logic [MS_W-1:0] qb
);

    // reciprocal rounded down, one bit above the dividend for a divisor of one
    localparam int RCP_W = MS_W + 1;
    localparam int DW    = $clog2(DIVISOR + 1);
    localparam logic [RCP_W-1:0] RCP_C = RCP_W'((64'd1 << MS_W) / 64'(DIVISOR));
    localparam logic [DW-1:0]    DIV_C = DW'(DIVISOR);
    localparam logic [MS_W-1:0]  DIV_X = MS_W'(DIVISOR);

    logic [2:0]            stage_reg, stage_next;
    logic                  done_reg, done_next;
    logic [MS_W-1:0]       xa_reg, xa_next;
    logic [MS_W-1:0]       xb_reg, xb_next;
    logic [MS_W-1:0]       qa_reg, qa_next;
    logic [MS_W-1:0]       qb_reg, qb_next;
    logic [MS_W-1:0]       ra_reg, ra_next;
    logic [MS_W-1:0]       rb_reg, rb_next;
    logic [MS_W+RCP_W-1:0] prod_a, prod_b;
    logic [MS_W+DW-1:0]    back_a, back_b;

    // estimate, remainder, correction
    always_comb begin
        prod_a     = xa_reg * RCP_C;
        prod_b     = xb_reg * RCP_C;
        back_a     = qa_reg * DIV_C;
        back_b     = qb_reg * DIV_C;
        stage_next = {stage_reg[1:0], start};
        done_next  = stage_reg[2];
        xa_next    = xa_reg;
        xb_next    = xb_reg;
        qa_next    = qa_reg;
        qb_next    = qb_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        if (start) begin
            xa_next = a_in;
            xb_next = b_in;
        end
        if (stage_reg[0]) begin
            qa_next = prod_a[2*MS_W-1:MS_W];
            qb_next = prod_b[2*MS_W-1:MS_W];
        end
        if (stage_reg[1]) begin
            ra_next = xa_reg - back_a[MS_W-1:0];
            rb_next = xb_reg - back_b[MS_W-1:0];
        end
        if (stage_reg[2]) begin
            if (ra_reg >= DIV_X) begin
                qa_next = qa_reg + 1'b1;
            end
            if (rb_reg >= DIV_X) begin
                qb_next = qb_reg + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        xa_reg <= xa_next;
        xb_reg <= xb_next;
        qa_reg <= qa_next;
        qb_reg <= qb_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
    end

    assign done = done_reg;
    assign qa   = qa_reg;
    assign qb   = qb_reg;

endmodule

FILE: rtl/ptts_mem.sv
// ----------------------------------------------------------------------------
// ptts_mem
// Task table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptts_mem import ptts_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic               aclk,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [ENTRY_W-1:0] rd_data,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [ENTRY_W-1:0] wr_data
);

    logic [ENTRY_W-1:0] mem_array [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // read port, data held while no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/ptts_checker.sv
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level checks of the periodic task tick scheduler, bound to the top.
// ----------------------------------------------------------------------------
module ptts_checker import ptts_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser,
    input logic                 m_tlast
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result word changed");

    // one command at a time: busy right after a word is taken
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while a command is in progress");

    // a run is always reported with ok status
    a_run_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tuser == STATUS_OK)
        else $error("run result with error status");

    // a result without a run closes its command
    a_norun_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[4] |-> m_tlast && (m_tdata[12:5] == '0))
        else $error("non-run result not last or with a handle");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the periodic task tick scheduler. Commands go in as
// stream words and each one is also applied to a copy of the task table kept
// here; that copy gives the replies the block must return, in order. The
// replies are then checked field by field as they come out. The run steps
// through a directed set of commands, a full table, pending runs building up
// over several ticks, a long output stall and a random mix. Both ports idle
// at random.
// ----------------------------------------------------------------------------
module tb import ptts_pkg::*; ;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TASKS    = 16;
    localparam int TICK_MS      = 10;
    localparam int IDLE_PCT     = 17;
    localparam int RANDOM_WORDS = 50;
    localparam int PEND_TICKS   = 6;
    localparam int STALL_CYCLES = 400;
    localparam int TAIL_CYCLES  = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_CAP    = 40;

    // highest code the command field can carry, decoded as nothing
    localparam cmd_t CMD_TOP = '1;

    typedef struct packed {
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  run_valid;
        logic [HANDLE_W-1:0]   run_handle;
        logic                  last;
    } reply_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // s_tdata: task_handle[7:0], delay_ms[39:8], period_ms[71:40],
    //          slot_to_delete[77:72], zero fill[79:78]
    logic [S_TDATA_W-1:0] s_tdata;
    // s_tuser: command[2:0]
    logic [CMD_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // m_tdata: slot[3:0], run_valid[4], run_handle[12:5], zero fill[15:13]
    logic [M_TDATA_W-1:0] m_tdata;
    // m_tuser: status[1:0]
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;

    // shadow task table
    bit                tbl_valid   [MAX_TASKS];
    bit [HANDLE_W-1:0] tbl_handle  [MAX_TASKS];
    bit [MS_W-1:0]     tbl_delay   [MAX_TASKS];
    bit [MS_W-1:0]     tbl_period  [MAX_TASKS];
    bit [PEND_W-1:0]   tbl_pending [MAX_TASKS];
    int                tbl_count;

    reply_t due_replies [$];
    int     error_count = 0;
    int     cycle_count = 0;
    int     hold_left   = 0;
    bit     calm        = 1'b0;

    periodic_task_tick_scheduler #(
        .MAX_TASKS (MAX_TASKS),
        .TICK_MS   (TICK_MS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < PRINT_CAP)
            $display("tb: mismatch in %s: got %0d, want %0d (cycle %0d)",
                     what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic void push_reply(input status_t st, input int slot_no,
                                       input logic rv, input logic [HANDLE_W-1:0] hnd);
        reply_t r;
        r = '{st, slot_no[SLOT_OUT_W-1:0], rv, hnd, 1'b1};
        due_replies.push_back(r);
    endfunction

    // remove one entry and close the gap behind it
    function automatic void drop_entry(input int s);
        bit was;
        int i;
        was = tbl_valid[s];
        for (i = s; i < MAX_TASKS - 1; i++) begin
            tbl_valid[i]   = tbl_valid[i + 1];
            tbl_handle[i]  = tbl_handle[i + 1];
            tbl_delay[i]   = tbl_delay[i + 1];
            tbl_period[i]  = tbl_period[i + 1];
            tbl_pending[i] = tbl_pending[i + 1];
        end
        tbl_valid[MAX_TASKS - 1]   = 1'b0;
        tbl_handle[MAX_TASKS - 1]  = '0;
        tbl_delay[MAX_TASKS - 1]   = '0;
        tbl_period[MAX_TASKS - 1]  = '0;
        tbl_pending[MAX_TASKS - 1] = '0;
        if (was && tbl_count > 0)
            tbl_count--;
    endfunction

    // apply one accepted command to the shadow table and queue its replies
    function automatic void schedule_step(input cmd_t cmd, input logic [HANDLE_W-1:0] hnd,
                                          input logic [MS_W-1:0] dly,
                                          input logic [MS_W-1:0] prd,
                                          input logic [DEL_W-1:0] del_slot);
        int     i;
        int     n;
        int     free_slot;
        bit     have;
        reply_t held;
        case (cmd)
            CMD_TICK: begin
                for (i = 0; i < MAX_TASKS; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_delay[i] == 0) begin
                            if (tbl_pending[i] != PEND_MAX)
                                tbl_pending[i]++;
                            if (tbl_period[i] != 0)
                                tbl_delay[i] = tbl_period[i];
                        end else begin
                            tbl_delay[i]--;
                        end
                    end
                end
                push_reply(STATUS_OK, 0, 1'b0, '0);
            end
            CMD_ADD: begin
                free_slot = MAX_TASKS;
                for (i = MAX_TASKS - 1; i >= 0; i--)
                    if (!tbl_valid[i])
                        free_slot = i;
                if (free_slot == MAX_TASKS) begin
                    push_reply(STATUS_FULL, 0, 1'b0, '0);
                end else begin
                    tbl_valid[free_slot]   = 1'b1;
                    tbl_handle[free_slot]  = hnd;
                    tbl_delay[free_slot]   = dly / MS_W'(TICK_MS);
                    tbl_period[free_slot]  = prd / MS_W'(TICK_MS);
                    tbl_pending[free_slot] = '0;
                    tbl_count++;
                    push_reply(STATUS_OK, free_slot, 1'b0, '0);
                end
            end
            CMD_DISPATCH: begin
                // a run is held back until the next one shows it is not the last
                n    = 0;
                i    = 0;
                have = 1'b0;
                while (i < MAX_TASKS && n < RESULT_CAP) begin
                    if (tbl_valid[i] && tbl_pending[i] != 0) begin
                        if (have)
                            due_replies.push_back(held);
                        held = '{STATUS_OK, i[SLOT_OUT_W-1:0], 1'b1, tbl_handle[i], 1'b0};
                        have = 1'b1;
                        n++;
                        tbl_pending[i]--;
                        // a one-shot goes; the entry shifted in is looked at next
                        if (tbl_period[i] == 0)
                            drop_entry(i);
                        else
                            i++;
                    end else begin
                        i++;
                    end
                end
                if (have) begin
                    held.last = 1'b1;
                    due_replies.push_back(held);
                end else begin
                    push_reply(STATUS_OK, 0, 1'b0, '0);
                end
            end
            CMD_DELETE: begin
                if (del_slot >= MAX_TASKS) begin
                    push_reply(STATUS_RANGE, del_slot, 1'b0, '0);
                end else begin
                    if (tbl_valid[del_slot])
                        drop_entry(del_slot);
                    push_reply(STATUS_OK, del_slot, 1'b0, '0);
                end
            end
            CMD_CLEAR: begin
                for (i = 0; i < MAX_TASKS; i++) begin
                    tbl_valid[i]   = 1'b0;
                    tbl_handle[i]  = '0;
                    tbl_delay[i]   = '0;
                    tbl_period[i]  = '0;
                    tbl_pending[i] = '0;
                end
                tbl_count = 0;
                push_reply(STATUS_OK, 0, 1'b0, '0);
            end
            default: begin
                push_reply(STATUS_OK, 0, 1'b0, '0);
            end
        endcase
    endfunction

    // offer one command word, predict once it is taken
    task automatic issue_cmd(input cmd_t cmd, input logic [HANDLE_W-1:0] hnd,
                             input logic [MS_W-1:0] dly, input logic [MS_W-1:0] prd,
                             input logic [DEL_W-1:0] del_slot);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({del_slot, prd, dly, hnd});
        do @(posedge aclk); while (!s_tready);
        schedule_step(cmd, hnd, dly, prd, del_slot);
    endtask

    // command whose add and delete fields carry noise
    task automatic issue_plain(input cmd_t cmd);
        issue_cmd(cmd, HANDLE_W'($urandom), $urandom, $urandom, DEL_W'($urandom));
    endtask

    // stop offering until every predicted reply is back
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (due_replies.size() != 0);
    endtask

    // result port: random stalls, or a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // compare every reply word with the oldest prediction
    initial begin
        reply_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (due_replies.size() == 0) begin
                    report_mismatch("unexpected word, slot", m_tdata[SLOT_OUT_W-1:0], 0);
                end else begin
                    want = due_replies.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[SLOT_OUT_W-1:0] !== want.slot)
                        report_mismatch("slot", m_tdata[SLOT_OUT_W-1:0], want.slot);
                    if (m_tdata[SLOT_OUT_W] !== want.run_valid)
                        report_mismatch("run_valid", m_tdata[SLOT_OUT_W], want.run_valid);
                    if (m_tdata[SLOT_OUT_W+HANDLE_W:SLOT_OUT_W+1] !== want.run_handle)
                        report_mismatch("run_handle",
                                        m_tdata[SLOT_OUT_W+HANDLE_W:SLOT_OUT_W+1],
                                        want.run_handle);
                    if (m_tlast !== want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
            end
        end
    end

    // every command and the corner cases of each
    task automatic test_directed_ops();
        int c;
        issue_plain(CMD_TICK);
        issue_plain(CMD_DISPATCH);
        issue_cmd(CMD_ADD, 8'h00, '0, '0, '0);
        // values below one tick round down to zero
        issue_cmd(CMD_ADD, 8'h5A, MS_W'(TICK_MS - 1), MS_W'(TICK_MS - 1), '1);
        issue_cmd(CMD_ADD, 8'hFF, '0, MS_W'(TICK_MS), '0);
        issue_cmd(CMD_ADD, 8'h81, '1, '1, '1);
        issue_plain(CMD_TICK);
        // two one-shots at the head: each entry shifted in still runs this pass
        issue_plain(CMD_DISPATCH);
        issue_plain(CMD_TICK);
        issue_plain(CMD_TICK);
        issue_plain(CMD_DISPATCH);
        // out of range at both ends, empty slot in range, then a live one
        issue_cmd(CMD_DELETE, HANDLE_W'($urandom), $urandom, $urandom, '1);
        issue_cmd(CMD_DELETE, HANDLE_W'($urandom), $urandom, $urandom, DEL_W'(MAX_TASKS));
        issue_cmd(CMD_DELETE, HANDLE_W'($urandom), $urandom, $urandom,
                  DEL_W'(MAX_TASKS - 1));
        issue_cmd(CMD_DELETE, HANDLE_W'($urandom), $urandom, $urandom, '0);
        for (c = CMD_CLEAR + 1; c <= CMD_TOP; c++)
            issue_plain(cmd_t'(c));
        issue_plain(CMD_CLEAR);
        issue_plain(CMD_DISPATCH);
        drain_replies();
    endtask

    // fill every slot, overflow once, then run the whole table in one pass
    task automatic test_full_table();
        int k;
        calm = 1'b1;
        issue_plain(CMD_CLEAR);
        for (k = 0; k < MAX_TASKS; k++)
            issue_cmd(CMD_ADD, HANDLE_W'($urandom), $urandom_range(TICK_MS - 1),
                      k[0] ? $urandom_range(99, TICK_MS) : $urandom_range(TICK_MS - 1),
                      DEL_W'($urandom));
        issue_plain(CMD_ADD);
        issue_plain(CMD_TICK);
        issue_plain(CMD_DISPATCH);
        calm = 1'b0;
        drain_replies();
    endtask

    // runs pile up over several ticks, then drain one per dispatch until none is left
    task automatic test_pending_runs();
        issue_plain(CMD_CLEAR);
        issue_cmd(CMD_ADD, HANDLE_W'($urandom), '0, MS_W'(TICK_MS), DEL_W'($urandom));
        repeat (PEND_TICKS) issue_plain(CMD_TICK);
        repeat (PEND_TICKS) issue_plain(CMD_DISPATCH);
        drain_replies();
    endtask

    // result port held off while commands keep coming
    task automatic test_output_stall();
        int k;
        issue_plain(CMD_CLEAR);
        for (k = 0; k < 6; k++)
            issue_cmd(CMD_ADD, HANDLE_W'($urandom), '0, k[0] ? MS_W'(TICK_MS) : '0,
                      DEL_W'($urandom));
        issue_plain(CMD_TICK);
        hold_left = STALL_CYCLES;
        issue_plain(CMD_DISPATCH);
        repeat (4) begin
            issue_plain(CMD_TICK);
            issue_plain(CMD_DISPATCH);
        end
        issue_plain(CMD_ADD);
        drain_replies();
    endtask

    // random mix, biased to keep the table busy with short delays
    task automatic test_random_mix();
        int                  k;
        int                  roll;
        cmd_t                cmd;
        logic [HANDLE_W-1:0] hnd;
        logic [MS_W-1:0]     dly;
        logic [MS_W-1:0]     prd;
        logic [DEL_W-1:0]    del_slot;
        for (k = 0; k < RANDOM_WORDS; k++) begin
            calm     = (k >= RANDOM_WORDS / 3) && (k < RANDOM_WORDS / 2);
            roll     = $urandom_range(99);
            hnd      = HANDLE_W'($urandom);
            dly      = $urandom;
            prd      = $urandom;
            del_slot = DEL_W'($urandom);
            if (roll < 30) begin
                cmd = CMD_TICK;
            end else if (roll < 55) begin
                cmd = CMD_ADD;
                if ($urandom_range(3) != 0)
                    dly = $urandom_range(60);
                roll = $urandom_range(9);
                if (roll < 3)
                    prd = $urandom_range(TICK_MS - 1);
                else if (roll < 8)
                    prd = $urandom_range(60, TICK_MS);
            end else if (roll < 75) begin
                cmd = CMD_DISPATCH;
            end else if (roll < 89) begin
                cmd = CMD_DELETE;
                if ($urandom_range(4) != 0)
                    del_slot = DEL_W'($urandom_range(MAX_TASKS - 1));
                else
                    del_slot = DEL_W'($urandom_range((1 << DEL_W) - 1, MAX_TASKS));
            end else if (roll < 92) begin
                cmd = CMD_CLEAR;
            end else if (roll < 95) begin
                cmd = cmd_t'($urandom_range(CMD_TOP, CMD_CLEAR + 1));
            end else begin
                // add with full-range delay and period
                cmd = CMD_ADD;
            end
            issue_cmd(cmd, hnd, dly, prd, del_slot);
        end
        calm = 1'b0;
        drain_replies();
    endtask

    // sequence
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_TICK;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_ops();
        test_full_table();
        test_pending_runs();
        test_output_stall();
        test_random_mix();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (due_replies.size() != 0)
            report_mismatch("replies never delivered", due_replies.size(), 0);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
